@@ rtl/p1sf_pkg.sv @@
// ============================================================================
// p1sf_pkg - shared types and constants for the P1 shape function evaluator
// Element kinds, fixed-point formats and the front-to-back command record.
// ============================================================================
package p1sf_pkg;

    localparam int FRAC_BITS = 16;
    localparam int CW = 18;
    localparam int OW = 21;
    localparam int WW = 20;

    localparam logic [3:0] K_VERTEX = 4'd0;
    localparam logic [3:0] K_EDGE   = 4'd1;
    localparam logic [3:0] K_TRI    = 4'd2;
    localparam logic [3:0] K_QUAD   = 4'd3;
    localparam logic [3:0] K_TET    = 4'd4;
    localparam logic [3:0] K_PYR    = 4'd5;
    localparam logic [3:0] K_PRISM  = 4'd6;
    localparam logic [3:0] K_HEX    = 4'd7;
    localparam logic [3:0] K_OCT    = 4'd8;

    localparam logic signed [WW-1:0] ONE = WW'(1) <<< FRAC_BITS;

    typedef struct packed {
        logic [3:0]           kind;
        logic [2:0]           idx;
        logic                 err;
        logic                 gt;
        logic                 neg;
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cmd_t;

    function automatic logic [3:0] corner_count(input logic [3:0] k);
        case (k)
            K_VERTEX: corner_count = 4'd1;
            K_EDGE:   corner_count = 4'd2;
            K_TRI:    corner_count = 4'd3;
            K_QUAD:   corner_count = 4'd4;
            K_TET:    corner_count = 4'd4;
            K_PYR:    corner_count = 4'd5;
            K_PRISM:  corner_count = 4'd6;
            K_HEX:    corner_count = 4'd8;
            K_OCT:    corner_count = 4'd6;
            default:  corner_count = 4'd0;
        endcase
    endfunction

    // floor product of two Q values of WW bits, result kept at WW+2 bits
    function automatic logic signed [WW+1:0] fmul(input logic signed [WW-1:0] a,
                                                 input logic signed [WW-1:0] b);
        logic signed [2*WW-1:0] p;
        p = a * b;
        fmul = (WW+2)'(p >>> FRAC_BITS);
    endfunction

    // floor product of a WW+2 bit Q value and a WW bit Q value
    function automatic logic signed [WW+1:0] fmul_wide(input logic signed [WW+1:0] a,
                                                      input logic signed [WW-1:0] b);
        logic signed [2*WW+1:0] p;
        p = a * b;
        fmul_wide = (WW+2)'(p >>> FRAC_BITS);
    endfunction

    function automatic logic signed [OW-1:0] sat(input logic signed [WW+1:0] v);
        if (v > (WW+2)'(1048575))
            sat = OW'(1048575);
        else if (v < -(WW+2)'(1048576))
            sat = OW'(-1048576);
        else
            sat = OW'(v);
    endfunction

endpackage

@@ rtl/p1sf_front.sv @@
// ============================================================================
// p1sf_front - command intake
// Holds the element kind and classifies each item into a command for the queue.
// ============================================================================
module p1sf_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [3:0]                cfg_wdata,
    input  logic [2:0]                shape_index,
    input  logic signed [p1sf_pkg::CW-1:0] coord_x,
    input  logic signed [p1sf_pkg::CW-1:0] coord_y,
    input  logic signed [p1sf_pkg::CW-1:0] coord_z,
    output p1sf_pkg::cmd_t            cmd
);
    logic [3:0] kind_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= 4'd0;
        else if (cfg_we)
            kind_reg <= cfg_wdata;
    end

    always_comb
    begin
        cmd.kind = kind_reg;
        cmd.idx  = shape_index;
        cmd.err  = {1'b0, shape_index} >= p1sf_pkg::corner_count(kind_reg);
        cmd.gt   = coord_x > coord_y;
        cmd.neg  = coord_z[p1sf_pkg::CW-1];
        cmd.x    = coord_x;
        cmd.y    = coord_y;
        cmd.z    = coord_z;
    end
endmodule

@@ rtl/p1sf_queue.sv @@
// ============================================================================
// p1sf_queue - two-entry command queue
// Decouples intake from evaluation.
// ============================================================================
module p1sf_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  p1sf_pkg::cmd_t din,
    input  logic           pop,
    output logic           not_empty,
    output logic           full,
    output p1sf_pkg::cmd_t dout
);
    p1sf_pkg::cmd_t mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign not_empty = cnt_reg != 2'd0;
    assign full      = cnt_reg == 2'd2;
    assign dout      = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= ~wp_reg;
            if (pop)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

@@ rtl/p1sf_back.sv @@
// ============================================================================
// p1sf_back - shape function evaluation
// Stage 1 forms first products, stage 2 the final terms, then saturate.
// ============================================================================
module p1sf_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    input  p1sf_pkg::cmd_t                 cmd,
    output logic                           done,
    output logic signed [p1sf_pkg::OW-1:0] shape_value,
    output logic signed [p1sf_pkg::OW-1:0] grad_x,
    output logic signed [p1sf_pkg::OW-1:0] grad_y,
    output logic signed [p1sf_pkg::OW-1:0] grad_z,
    output logic                           index_error
);
    localparam int WW = p1sf_pkg::WW;
    typedef logic signed [WW-1:0] w_t;
    typedef logic signed [WW+1:0] e_t;

    w_t x, y, z, u, w, t;
    always_comb
    begin
        x = WW'(cmd.x);
        y = WW'(cmd.y);
        z = WW'(cmd.z);
        u = p1sf_pkg::ONE - x;
        w = p1sf_pkg::ONE - y;
        t = p1sf_pkg::ONE - z;
    end

    // stage 1: pairwise products and operands
    logic         v1_reg;
    p1sf_pkg::cmd_t c1_reg;
    e_t uw_reg, xw_reg, xy_reg, uy_reg, zy_reg, zx_reg;
    e_t wt_reg, ut_reg, xt_reg, yt_reg, wz_reg, uz_reg, xz_reg, yz_reg;
    e_t pt_reg, pz_reg;
    w_t u1_reg, w1_reg, t1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        c1_reg <= cmd;
        u1_reg <= u;
        w1_reg <= w;
        t1_reg <= t;
        uw_reg <= p1sf_pkg::fmul(u, w);
        xw_reg <= p1sf_pkg::fmul(x, w);
        xy_reg <= p1sf_pkg::fmul(x, y);
        uy_reg <= p1sf_pkg::fmul(u, y);
        zy_reg <= p1sf_pkg::fmul(z, y - p1sf_pkg::ONE);
        zx_reg <= p1sf_pkg::fmul(z, x - p1sf_pkg::ONE);
        wt_reg <= p1sf_pkg::fmul(w, t);
        ut_reg <= p1sf_pkg::fmul(u, t);
        xt_reg <= p1sf_pkg::fmul(x, t);
        yt_reg <= p1sf_pkg::fmul(y, t);
        wz_reg <= p1sf_pkg::fmul(w, z);
        uz_reg <= p1sf_pkg::fmul(u, z);
        xz_reg <= p1sf_pkg::fmul(x, z);
        yz_reg <= p1sf_pkg::fmul(y, z);
        pt_reg <= p1sf_pkg::fmul(p1sf_pkg::ONE - x - y, t);
        pz_reg <= p1sf_pkg::fmul(p1sf_pkg::ONE - x - y, z);
    end

    // pyramid terms z*y and z*x reuse stage-1 products plus a correction
    e_t s, gx, gy, gz, zyp, zxp, hp;
    w_t x1, y1, z1, za, pp;

    always_comb
    begin
        x1  = WW'(c1_reg.x);
        y1  = WW'(c1_reg.y);
        z1  = WW'(c1_reg.z);
        za  = c1_reg.neg ? -z1 : z1;
        pp  = p1sf_pkg::ONE - x1 - y1;
        zyp = zy_reg;
        zxp = zx_reg;
        hp  = '0;
        s = '0; gx = '0; gy = '0; gz = '0;
        case (c1_reg.kind)
            p1sf_pkg::K_VERTEX: s = e_t'(p1sf_pkg::ONE);
            p1sf_pkg::K_EDGE:
                if (c1_reg.idx == 3'd0)
                begin
                    s = e_t'(u1_reg); gx = -e_t'(p1sf_pkg::ONE);
                end
                else
                begin
                    s = e_t'(x1); gx = e_t'(p1sf_pkg::ONE);
                end
            p1sf_pkg::K_TRI:
                case (c1_reg.idx)
                    3'd0:    begin s = e_t'(pp); gx = -e_t'(p1sf_pkg::ONE);
                                   gy = -e_t'(p1sf_pkg::ONE); end
                    3'd1:    begin s = e_t'(x1); gx = e_t'(p1sf_pkg::ONE); end
                    default: begin s = e_t'(y1); gy = e_t'(p1sf_pkg::ONE); end
                endcase
            p1sf_pkg::K_QUAD:
                case (c1_reg.idx)
                    3'd0:    begin s = e_t'(uw_reg); gx = -e_t'(w1_reg); gy = -e_t'(u1_reg); end
                    3'd1:    begin s = e_t'(xw_reg); gx = e_t'(w1_reg); gy = -e_t'(x1); end
                    3'd2:    begin s = e_t'(xy_reg); gx = e_t'(y1); gy = e_t'(x1); end
                    default: begin s = e_t'(uy_reg); gx = -e_t'(y1); gy = e_t'(u1_reg); end
                endcase
            p1sf_pkg::K_TET:
                case (c1_reg.idx)
                    3'd0:    begin s = e_t'(pp) - e_t'(z1); gx = -e_t'(p1sf_pkg::ONE);
                                   gy = -e_t'(p1sf_pkg::ONE); gz = -e_t'(p1sf_pkg::ONE); end
                    3'd1:    begin s = e_t'(x1); gx = e_t'(p1sf_pkg::ONE); end
                    3'd2:    begin s = e_t'(y1); gy = e_t'(p1sf_pkg::ONE); end
                    default: begin s = e_t'(z1); gz = e_t'(p1sf_pkg::ONE); end
                endcase
            p1sf_pkg::K_PYR:
            begin
                // fmul(z,y) = fmul(z,y-1)+z exactly, since z*one is whole
                hp = c1_reg.gt ? zyp + e_t'(z1) : zxp + e_t'(z1);
                case (c1_reg.idx)
                    3'd0:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(uw_reg) + e_t'(zyp); gx = -e_t'(w1_reg);
                            gy = -e_t'(u1_reg) + e_t'(z1); gz = -e_t'(w1_reg);
                        end
                        else
                        begin
                            s = e_t'(uw_reg) + e_t'(zxp); gx = -e_t'(w1_reg) + e_t'(z1);
                            gy = -e_t'(u1_reg); gz = -e_t'(u1_reg);
                        end
                    3'd1:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(xw_reg) - e_t'(hp); gx = e_t'(w1_reg);
                            gy = -e_t'(x1) - e_t'(z1); gz = -e_t'(y1);
                        end
                        else
                        begin
                            s = e_t'(xw_reg) - e_t'(hp); gx = e_t'(w1_reg) - e_t'(z1);
                            gy = -e_t'(x1); gz = -e_t'(x1);
                        end
                    3'd2:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(xy_reg) + e_t'(hp); gx = e_t'(y1);
                            gy = e_t'(x1) + e_t'(z1); gz = e_t'(y1);
                        end
                        else
                        begin
                            s = e_t'(xy_reg) + e_t'(hp); gx = e_t'(y1) + e_t'(z1);
                            gy = e_t'(x1); gz = e_t'(x1);
                        end
                    3'd3:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(uy_reg) - e_t'(hp); gx = -e_t'(y1);
                            gy = e_t'(u1_reg) - e_t'(z1); gz = -e_t'(y1);
                        end
                        else
                        begin
                            s = e_t'(uy_reg) - e_t'(hp); gx = -e_t'(y1) - e_t'(z1);
                            gy = e_t'(u1_reg); gz = -e_t'(x1);
                        end
                    default: begin s = e_t'(z1); gz = e_t'(p1sf_pkg::ONE); end
                endcase
            end
            p1sf_pkg::K_PRISM:
                case (c1_reg.idx)
                    3'd0:    begin s = e_t'(pt_reg); gx = -e_t'(t1_reg); gy = -e_t'(t1_reg);
                                   gz = -e_t'(pp); end
                    3'd1:    begin s = e_t'(xt_reg); gx = e_t'(t1_reg); gz = -e_t'(x1); end
                    3'd2:    begin s = e_t'(yt_reg); gy = e_t'(t1_reg); gz = -e_t'(y1); end
                    3'd3:    begin s = e_t'(pz_reg); gx = -e_t'(z1); gy = -e_t'(z1);
                                   gz = e_t'(pp); end
                    3'd4:    begin s = e_t'(xz_reg); gx = e_t'(z1); gz = e_t'(x1); end
                    default: begin s = e_t'(yz_reg); gy = e_t'(z1); gz = e_t'(y1); end
                endcase
            p1sf_pkg::K_HEX:
                case (c1_reg.idx)
                    3'd0: begin gx = -e_t'(wt_reg); gy = -e_t'(ut_reg); gz = -e_t'(uw_reg); end
                    3'd1: begin gx = e_t'(wt_reg); gy = -e_t'(xt_reg); gz = -e_t'(xw_reg); end
                    3'd2: begin gx = e_t'(yt_reg); gy = e_t'(xt_reg); gz = -e_t'(xy_reg); end
                    3'd3: begin gx = -e_t'(yt_reg); gy = e_t'(ut_reg); gz = -e_t'(uy_reg); end
                    3'd4: begin gx = -e_t'(wz_reg); gy = -e_t'(uz_reg); gz = e_t'(uw_reg); end
                    3'd5: begin gx = e_t'(wz_reg); gy = -e_t'(xz_reg); gz = e_t'(xw_reg); end
                    3'd6: begin gx = e_t'(yz_reg); gy = e_t'(xz_reg); gz = e_t'(xy_reg); end
                    default: begin gx = -e_t'(yz_reg); gy = e_t'(uz_reg); gz = e_t'(uy_reg); end
                endcase
            p1sf_pkg::K_OCT:
                case (c1_reg.idx)
                    3'd0:
                        if (c1_reg.neg)
                        begin
                            s = -e_t'(z1); gz = -e_t'(p1sf_pkg::ONE);
                        end
                    3'd1:
                    begin
                        if (c1_reg.gt)
                        begin
                            s = e_t'(p1sf_pkg::ONE) - e_t'(x1) - e_t'(za);
                            gx = -e_t'(p1sf_pkg::ONE);
                        end
                        else
                        begin
                            s = e_t'(p1sf_pkg::ONE) - e_t'(y1) - e_t'(za);
                            gy = -e_t'(p1sf_pkg::ONE);
                        end
                        gz = c1_reg.neg ? e_t'(p1sf_pkg::ONE) : -e_t'(p1sf_pkg::ONE);
                    end
                    3'd2:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(x1) - e_t'(y1); gx = e_t'(p1sf_pkg::ONE);
                            gy = -e_t'(p1sf_pkg::ONE);
                        end
                    3'd3:
                        if (c1_reg.gt)
                        begin
                            s = e_t'(y1); gy = e_t'(p1sf_pkg::ONE);
                        end
                        else
                        begin
                            s = e_t'(x1); gx = e_t'(p1sf_pkg::ONE);
                        end
                    3'd4:
                        if (!c1_reg.gt)
                        begin
                            s = e_t'(y1) - e_t'(x1); gx = -e_t'(p1sf_pkg::ONE);
                            gy = e_t'(p1sf_pkg::ONE);
                        end
                    default:
                        if (!c1_reg.neg)
                        begin
                            s = e_t'(z1); gz = e_t'(p1sf_pkg::ONE);
                        end
                endcase
            default: ;
        endcase
    end

    // hex value needs a third product: keep its operands for stage 2
    e_t hexa;
    w_t hexb;
    always_comb
    begin
        case (c1_reg.idx)
            3'd0, 3'd4: hexa = uw_reg;
            3'd1, 3'd5: hexa = xw_reg;
            3'd2, 3'd6: hexa = xy_reg;
            default:    hexa = uy_reg;
        endcase
        hexb = c1_reg.idx[2] ? z1 : t1_reg;
    end

    logic v2_reg, err2_reg, hex2_reg;
    e_t   s2_reg, gx2_reg, gy2_reg, gz2_reg;
    e_t   ha_reg;
    w_t   hb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        err2_reg <= c1_reg.err;
        hex2_reg <= c1_reg.kind == p1sf_pkg::K_HEX;
        s2_reg   <= s;
        gx2_reg  <= gx;
        gy2_reg  <= gy;
        gz2_reg  <= gz;
        ha_reg   <= hexa;
        hb_reg   <= hexb;
    end

    e_t sf;
    always_comb
    begin
        sf = hex2_reg ? p1sf_pkg::fmul_wide(ha_reg, hb_reg) : s2_reg;
    end

    logic done_reg, err_reg;
    logic signed [p1sf_pkg::OW-1:0] sv_reg, gx_reg, gy_reg, gz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= v2_reg;
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err2_reg;
        sv_reg  <= err2_reg ? '0 : p1sf_pkg::sat(sf);
        gx_reg  <= err2_reg ? '0 : p1sf_pkg::sat(gx2_reg);
        gy_reg  <= err2_reg ? '0 : p1sf_pkg::sat(gy2_reg);
        gz_reg  <= err2_reg ? '0 : p1sf_pkg::sat(gz2_reg);
    end

    assign done        = done_reg;
    assign index_error = err_reg;
    assign shape_value = sv_reg;
    assign grad_x      = gx_reg;
    assign grad_y      = gy_reg;
    assign grad_z      = gz_reg;
endmodule

@@ rtl/p1_shape_function_eval_top.sv @@
// ============================================================================
// p1_shape_function_eval_top - first-order Lagrange shape function evaluator
// Evaluates one shape value and gradient per transfer for a chosen element.
// ============================================================================
// Throughput: one item per cycle; busy never rises, the evaluation pipeline
// has a fixed depth and the receiver cannot stall.
// Reset: the element kind returns to vertex, queue and pipeline empty.
module p1_shape_function_eval_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [3:0]                     cfg_wdata,
    input  logic                           start,
    output logic                           busy,
    input  logic [2:0]                     shape_index,
    input  logic signed [p1sf_pkg::CW-1:0] coord_x,
    input  logic signed [p1sf_pkg::CW-1:0] coord_y,
    input  logic signed [p1sf_pkg::CW-1:0] coord_z,
    output logic                           done,
    output logic signed [p1sf_pkg::OW-1:0] shape_value,
    output logic signed [p1sf_pkg::OW-1:0] grad_x,
    output logic signed [p1sf_pkg::OW-1:0] grad_y,
    output logic signed [p1sf_pkg::OW-1:0] grad_z,
    output logic                           index_error
);
    p1sf_pkg::cmd_t fcmd, qcmd;
    logic take, q_ne, q_full;

    assign busy = q_full;
    assign take = start && !busy;

    p1sf_front u_front (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .shape_index(shape_index), .coord_x(coord_x),
        .coord_y(coord_y), .coord_z(coord_z), .cmd(fcmd)
    );

    p1sf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(take), .din(fcmd), .pop(q_ne),
        .not_empty(q_ne), .full(q_full), .dout(qcmd)
    );

    p1sf_back u_back (
        .clk(clk), .rst_n(rst_n), .in_valid(q_ne), .cmd(qcmd), .done(done),
        .shape_value(shape_value), .grad_x(grad_x), .grad_y(grad_y),
        .grad_z(grad_z), .index_error(index_error)
    );
endmodule

@@ rtl/p1sf_checker.sv @@
// ============================================================================
// p1sf_checker - port-level checks
// Watches the top-level ports for result timing and error coding.
// ============================================================================
module p1sf_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           start,
    input logic                           busy,
    input logic                           done,
    input logic signed [p1sf_pkg::OW-1:0] shape_value,
    input logic signed [p1sf_pkg::OW-1:0] grad_x,
    input logic                           index_error
);
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && index_error |-> shape_value == '0 && grad_x == '0)
        else $error("error result not zero");

    a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");

    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##4 done)
        else $error("result missing");
endmodule

bind p1_shape_function_eval_top p1sf_checker u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
    .shape_value(shape_value), .grad_x(grad_x), .index_error(index_error)
);

@@ bench/tb_p1_shape_function_eval_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb_p1_shape_function_eval_top - shape function evaluator testbench
// Drives coordinates and corner indexes for every element kind, predicts the
// shape value and gradient in fixed point, and checks each done transfer.
// ============================================================================
module tb_p1_shape_function_eval_top;
    import p1sf_pkg::*;

    typedef struct {
        logic signed [OW-1:0] value;
        logic signed [OW-1:0] gx;
        logic signed [OW-1:0] gy;
        logic signed [OW-1:0] gz;
        logic                 err;
    } shape_res_t;

    class shape_scoreboard;
        shape_res_t pending[$];
        int         mismatches;
        logic [3:0] kind;

        function longint fl_mul(longint a, longint b);
            fl_mul = (a * b) >>> FRAC_BITS;
        endfunction

        function logic signed [OW-1:0] clip(longint v);
            if (v > 1048575)
                clip = OW'(1048575);
            else if (v < -1048576)
                clip = OW'(-1048576);
            else
                clip = OW'(v);
        endfunction

        function void note_item(logic [2:0] idx, logic signed [CW-1:0] cx,
                                logic signed [CW-1:0] cy, logic signed [CW-1:0] cz);
            shape_res_t r;
            longint one, x, y, z, u, w, t, s, gx, gy, gz, p, za;
            int     cnt;
            bit     gt, neg;
            one = longint'(1) <<< FRAC_BITS;
            x = cx; y = cy; z = cz;
            u = one - x; w = one - y; t = one - z;
            s = 0; gx = 0; gy = 0; gz = 0;
            gt = x > y; neg = z < 0;
            case (kind)
                K_VERTEX: cnt = 1;
                K_EDGE:   cnt = 2;
                K_TRI:    cnt = 3;
                K_QUAD:   cnt = 4;
                K_TET:    cnt = 4;
                K_PYR:    cnt = 5;
                K_PRISM:  cnt = 6;
                K_HEX:    cnt = 8;
                K_OCT:    cnt = 6;
                default:  cnt = 0;
            endcase
            r.err = idx >= cnt;
            if (!r.err)
            begin
                case (kind)
                    K_VERTEX: s = one;
                    K_EDGE:
                        if (idx == 0) begin s = u; gx = -one; end
                        else begin s = x; gx = one; end
                    K_TRI:
                        case (idx)
                            0: begin s = one - x - y; gx = -one; gy = -one; end
                            1: begin s = x; gx = one; end
                            default: begin s = y; gy = one; end
                        endcase
                    K_QUAD:
                        case (idx)
                            0: begin s = fl_mul(u, w); gx = -w; gy = -u; end
                            1: begin s = fl_mul(x, w); gx = w; gy = -x; end
                            2: begin s = fl_mul(x, y); gx = y; gy = x; end
                            default: begin s = fl_mul(u, y); gx = -y; gy = u; end
                        endcase
                    K_TET:
                        case (idx)
                            0: begin s = one - x - y - z; gx = -one; gy = -one; gz = -one; end
                            1: begin s = x; gx = one; end
                            2: begin s = y; gy = one; end
                            default: begin s = z; gz = one; end
                        endcase
                    K_PYR:
                        case (idx)
                            0:
                                if (gt) begin
                                    s = fl_mul(u, w) + fl_mul(z, y - one);
                                    gx = -w; gy = -u + z; gz = -w;
                                end else begin
                                    s = fl_mul(u, w) + fl_mul(z, x - one);
                                    gx = -w + z; gy = -u; gz = -u;
                                end
                            1:
                                if (gt) begin
                                    s = fl_mul(x, w) - fl_mul(z, y);
                                    gx = w; gy = -x - z; gz = -y;
                                end else begin
                                    s = fl_mul(x, w) - fl_mul(z, x);
                                    gx = w - z; gy = -x; gz = -x;
                                end
                            2:
                                if (gt) begin
                                    s = fl_mul(x, y) + fl_mul(z, y);
                                    gx = y; gy = x + z; gz = y;
                                end else begin
                                    s = fl_mul(x, y) + fl_mul(z, x);
                                    gx = y + z; gy = x; gz = x;
                                end
                            3:
                                if (gt) begin
                                    s = fl_mul(u, y) - fl_mul(z, y);
                                    gx = -y; gy = u - z; gz = -y;
                                end else begin
                                    s = fl_mul(u, y) - fl_mul(z, x);
                                    gx = -y - z; gy = u; gz = -x;
                                end
                            default: begin s = z; gz = one; end
                        endcase
                    K_PRISM:
                    begin
                        p = one - x - y;
                        case (idx)
                            0: begin s = fl_mul(p, t); gx = -t; gy = -t; gz = -p; end
                            1: begin s = fl_mul(x, t); gx = t; gz = -x; end
                            2: begin s = fl_mul(y, t); gy = t; gz = -y; end
                            3: begin s = fl_mul(p, z); gx = -z; gy = -z; gz = p; end
                            4: begin s = fl_mul(x, z); gx = z; gz = x; end
                            default: begin s = fl_mul(y, z); gy = z; gz = y; end
                        endcase
                    end
                    K_HEX:
                    begin
                        longint a, b, c;
                        a = idx inside {1, 2, 5, 6} ? x : u;
                        b = idx inside {2, 3, 6, 7} ? y : w;
                        c = idx >= 4 ? z : t;
                        s  = fl_mul(fl_mul(a, b), c);
                        gx = fl_mul(b, c);
                        gy = fl_mul(a, c);
                        gz = fl_mul(a, b);
                        if (!(idx inside {1, 2, 5, 6})) gx = -gx;
                        if (!(idx inside {2, 3, 6, 7})) gy = -gy;
                        if (idx < 4) gz = -gz;
                    end
                    default:
                    begin
                        za = neg ? -z : z;
                        case (idx)
                            0: if (neg) begin s = -z; gz = -one; end
                            1:
                            begin
                                if (gt) begin s = one - x - za; gx = -one; end
                                else begin s = one - y - za; gy = -one; end
                                gz = neg ? one : -one;
                            end
                            2: if (gt) begin s = x - y; gx = one; gy = -one; end
                            3:
                                if (gt) begin s = y; gy = one; end
                                else begin s = x; gx = one; end
                            4: if (!gt) begin s = y - x; gx = -one; gy = one; end
                            default: if (!neg) begin s = z; gz = one; end
                        endcase
                    end
                endcase
            end
            r.value = clip(s); r.gx = clip(gx); r.gy = clip(gy); r.gz = clip(gz);
            pending.push_back(r);
        endfunction

        function void check_result(shape_res_t a);
            shape_res_t e;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer at %0t", $time);
                return;
            end
            e = pending.pop_front();
            if (a.value !== e.value || a.gx !== e.gx || a.gy !== e.gy ||
                a.gz !== e.gz || a.err !== e.err)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp %0d %0d %0d %0d %0b got %0d %0d %0d %0d %0b",
                             e.value, e.gx, e.gy, e.gz, e.err,
                             a.value, a.gx, a.gy, a.gz, a.err);
            end
        endfunction
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [3:0]           cfg_wdata = '0;
    logic                 start = 1'b0;
    logic                 busy;
    logic [2:0]           shape_index = '0;
    logic signed [CW-1:0] coord_x = '0;
    logic signed [CW-1:0] coord_y = '0;
    logic signed [CW-1:0] coord_z = '0;
    logic                 done;
    logic signed [OW-1:0] shape_value, grad_x, grad_y, grad_z;
    logic                 index_error;
    longint               cycles = 0;
    shape_scoreboard      sb;

    p1_shape_function_eval_top dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .start(start), .busy(busy), .shape_index(shape_index),
        .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z),
        .done(done), .shape_value(shape_value), .grad_x(grad_x),
        .grad_y(grad_y), .grad_z(grad_z), .index_error(index_error)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        shape_res_t r;
        cycles++;
        if (rst_n && done)
        begin
            r.value = shape_value; r.gx = grad_x; r.gy = grad_y; r.gz = grad_z;
            r.err = index_error;
            sb.check_result(r);
        end
        if (rst_n && start && !busy)
            sb.note_item(shape_index, coord_x, coord_y, coord_z);
        if (cycles > 400000)
        begin
            $display("p1_shape_function_eval_top verification failed");
            $finish;
        end
    end

    task automatic drain();
        start <= 1'b0;
        while (sb.pending.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    task automatic write_kind(logic [3:0] k);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.kind = k;
    endtask

    task automatic send(logic [2:0] idx, logic [CW-1:0] x, logic [CW-1:0] y,
                        logic [CW-1:0] z, bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 5) : 0;
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        shape_index <= idx;
        coord_x <= x; coord_y <= y; coord_z <= z;
        @(posedge clk);
        while (busy) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: rand_coord = 18'h1FFFF;
            1: rand_coord = 18'h20000;
            2, 3: rand_coord = $urandom_range(0, 65536);
            default: rand_coord = $urandom;
        endcase
    endfunction

    initial
    begin
        logic [3:0] kinds[$];
        bit         gaps;
        sb = new();
        sb.kind = K_VERTEX;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        send(0, 18'h10000, 0, 0, 0);
        send(7, 18'h1FFFF, 18'h20000, 18'h1FFFF, 0);
        write_kind(K_HEX);
        for (int i = 0; i < 8; i++)
            send(i, 18'h20000, 18'h1FFFF, 18'h20000, 0);
        write_kind(K_OCT);
        send(0, 18'h08000, 18'h04000, 18'h3C000, 0);
        send(1, 18'h04000, 18'h08000, 18'h04000, 0);
        send(2, 18'h08000, 18'h04000, 0, 0);
        send(3, 18'h04000, 18'h04000, 0, 0);
        send(4, 18'h04000, 18'h08000, 18'h3C000, 0);
        send(5, 0, 0, 18'h08000, 0);
        send(6, 0, 0, 0, 0);
        write_kind(4'd15);
        send(0, 0, 0, 0, 0);
        kinds = {K_EDGE, K_TRI, K_QUAD, K_TET, K_PYR, K_PRISM, K_HEX, K_OCT, 4'd9};
        for (int ph = 0; ph < 23; ph++)
        begin
            write_kind(ph < kinds.size() ? kinds[ph] : 4'($urandom_range(0, 15)));
            gaps = (ph % 3) != 2;
            for (int i = 0; i < 50; i++)
            begin
                if (i == 25 && ph == 4)
                    drain();
                send($urandom, rand_coord(), rand_coord(), rand_coord(), gaps);
            end
            start <= 1'b0;
        end
        start <= 1'b0;
        drain();
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("p1_shape_function_eval_top verification clean");
        else
            $display("p1_shape_function_eval_top verification failed");
        $finish;
    end
endmodule
